// ----- rtl/core/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfd_pkg: shared definitions of the two-by-two box filter downscaler
// Sizes, payload types, register indexes and the per-channel averaging helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

  // Largest frame the line store and the counters are built for.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field widths fixed by the register map and the pixel format.
  localparam int SIZE_W = 13;
  localparam int XW     = SIZE_W + 1;
  localparam int CH_W   = 8;
  localparam int SUM_W  = CH_W + 1;
  localparam int AVG_W  = CH_W + 2;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(1080);
  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(2);
  localparam logic [AVG_W-1:0]  ROUND_BIAS   = AVG_W'(2);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  // Three channel sums of a horizontal pixel pair, red in the low bits.
  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sum_t;

  localparam int ENTRY_W = $bits(sum_t);

  typedef struct packed {
    logic valid;
    logic last;
    sum_t pair;
  } issue_t;

  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] addr;
    sum_t               data;
  } ram_wr_t;

  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] addr;
  } ram_rd_t;

  // Limits a configured size to the range the hardware supports.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [XW-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v < MIN_SIZE) begin
      r = MIN_SIZE;
    end else if (XW'(v) > hi) begin
      r = hi[SIZE_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Rounded mean of two pair sums: (a + b + 2) / 4.
  function automatic logic [CH_W-1:0] avg_channel(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
    logic [AVG_W-1:0] s;
    s = AVG_W'(a) + AVG_W'(b) + ROUND_BIAS;
    return s[AVG_W-1:2];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bfd_in_if.sv -----
// ----------------------------------------------------------------------------
// bfd_in_if: input pixel channel
// One RGB pixel per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [bfd_pkg::CH_W-1:0]  red_in;
  logic [bfd_pkg::CH_W-1:0]  green_in;
  logic [bfd_pkg::CH_W-1:0]  blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bfd_out_if.sv -----
// ----------------------------------------------------------------------------
// bfd_out_if: output pixel channel
// One averaged RGB pixel and an end-of-frame flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_out_if;
  logic                      valid;
  logic                      ready;
  logic [bfd_pkg::CH_W-1:0]  red_out;
  logic [bfd_pkg::CH_W-1:0]  green_out;
  logic [bfd_pkg::CH_W-1:0]  blue_out;
  logic                      frame_last;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_last, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bfd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bfd_cfg_if: configuration write channel
// One register write per transfer: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_cfg_if;
  logic                        valid;
  logic                        ready;
  bfd_pkg::cfg_index_t         index;
  logic [bfd_pkg::SIZE_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/box_filter_downscale_by_two_unit.sv -----
// ----------------------------------------------------------------------------
// box_filter_downscale_by_two_unit: 2x2 box filter downscaler, RGB stream
// Halves a raster-order frame in both directions by rounded 2x2 averaging.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one RGB pixel per transfer in raster order, pix_out one
//   averaged pixel per completed 2x2 block, with frame_last set on the final
//   pixel of the halved frame. cfg writes frame_width and frame_height; write
//   it only while no block is in flight. Sizes are clamped to 2..MAX.
//   Even rows leave each column pair's sum in the line store; on odd rows the
//   second pixel of a pair reads the stored sum; the block is registered in
//   stage s1 and then averaged into the output register once that register
//   is free. A trailing odd column or odd last row is taken in without output.
//   Throughput: one pixel per cycle while stage s1 can take a block, with the
//   single read and single write port of the line store used on alternate
//   pixels only.
//   Reset (rst, synchronous) returns the sizes to 1920 by 1080 and the raster
//   position to the frame origin; the line store is not cleared, as every
//   entry is written on an even row before an odd row reads it.
//   When the receiver stalls, the output register holds its pixel and one
//   further block waits in the stage ahead of it; input transfers go on
//   until that stage is occupied as well.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_downscale_by_two_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  bfd_cfg_if.sink    cfg,
  bfd_in_if.sink     pix_in,
  bfd_out_if.source  pix_out
);

  bfd_pkg::issue_t  issue;
  bfd_pkg::ram_wr_t wr;
  bfd_pkg::ram_rd_t rd;
  bfd_pkg::sum_t    above;
  logic             avg_ready;

  // Raster position, size registers and line store addressing.
  bfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_in    (pix_in),
    .avg_ready (avg_ready),
    .issue     (issue),
    .wr        (wr),
    .rd        (rd)
  );

  // The line store holds one pair sum per output column. A read and a write
  // of the same entry are always at least a full input row apart, so no
  // forwarding path is needed.
  bfd_line_ram #(
    .DEPTH (bfd_pkg::LINE_DEPTH),
    .AW    (bfd_pkg::LINE_AW),
    .DW    (bfd_pkg::ENTRY_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (above)
  );

  // Block completion, rounding and the output register.
  bfd_avg u_avg (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .above   (above),
    .ready   (avg_ready),
    .pix_out (pix_out)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bfd_line_ram.sv -----
// ----------------------------------------------------------------------------
// bfd_line_ram: simple dual-port line store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_line_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 27
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfd_ctrl: raster counters, size registers and line store access
// Tracks pixel position, forms pair sums and issues line store reads/writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  bfd_cfg_if.sink            cfg,
  bfd_in_if.sink             pix_in,
  input  wire logic          avg_ready,
  output bfd_pkg::issue_t    issue,
  output bfd_pkg::ram_wr_t   wr,
  output bfd_pkg::ram_rd_t   rd
);

  localparam int XW = bfd_pkg::XW;
  localparam logic [XW-1:0] MAX_W_X = XW'(bfd_pkg::MAX_WIDTH);
  localparam logic [XW-1:0] MAX_H_X = XW'(bfd_pkg::MAX_HEIGHT);
  localparam logic [XW-1:0] ONE_X   = XW'(1);

  logic [bfd_pkg::SIZE_W-1:0] width;
  logic [bfd_pkg::SIZE_W-1:0] height;
  logic [bfd_pkg::COL_W-1:0]  col;
  logic [bfd_pkg::COL_W-1:0]  col_next;
  logic [bfd_pkg::ROW_W-1:0]  row;
  logic [bfd_pkg::ROW_W-1:0]  row_next;
  bfd_pkg::pix_t              first;
  bfd_pkg::pix_t              pix;
  bfd_pkg::sum_t              pair;

  logic [XW-1:0] col_x, row_x, w_last, h_last, out_w, out_h, ocol, orow;
  logic          accept, in_block, col_odd, row_odd, last_block;

  assign cfg.ready    = 1'b1;
  assign pix_in.ready = avg_ready;
  assign accept       = pix_in.valid && avg_ready;

  assign pix.red   = pix_in.red_in;
  assign pix.green = pix_in.green_in;
  assign pix.blue  = pix_in.blue_in;

  assign col_x  = XW'(col);
  assign row_x  = XW'(row);
  assign w_last = XW'(width) - ONE_X;
  assign h_last = XW'(height) - ONE_X;
  assign out_w  = XW'(width) >> 1;
  assign out_h  = XW'(height) >> 1;
  assign ocol   = col_x >> 1;
  assign orow   = row_x >> 1;

  assign in_block   = (ocol < out_w) && (orow < out_h);
  assign col_odd    = col[0];
  assign row_odd    = row[0];
  assign last_block = (ocol == out_w - ONE_X) && (orow == out_h - ONE_X);

  assign pair.red   = bfd_pkg::SUM_W'(first.red)   + bfd_pkg::SUM_W'(pix.red);
  assign pair.green = bfd_pkg::SUM_W'(first.green) + bfd_pkg::SUM_W'(pix.green);
  assign pair.blue  = bfd_pkg::SUM_W'(first.blue)  + bfd_pkg::SUM_W'(pix.blue);

  // Even rows store the pair, odd rows fetch the pair stored above.
  assign wr.en   = accept && in_block && col_odd && !row_odd;
  assign wr.addr = bfd_pkg::LINE_AW'(ocol);
  assign wr.data = pair;
  assign rd.en   = accept && in_block && col_odd && row_odd;
  assign rd.addr = bfd_pkg::LINE_AW'(ocol);

  assign issue.valid = rd.en;
  assign issue.last  = last_block;
  assign issue.pair  = pair;

  // A counter at or past its last position wraps, also after a size change.
  always_comb begin
    if (col_x >= w_last) begin
      col_next = '0;
      if (row_x >= h_last) begin
        row_next = '0;
      end else begin
        row_next = bfd_pkg::ROW_W'(row_x + ONE_X);
      end
    end else begin
      col_next = bfd_pkg::COL_W'(col_x + ONE_X);
      if (row_x > h_last) begin
        row_next = '0;
      end else begin
        row_next = row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= bfd_pkg::clamp_size(bfd_pkg::RESET_WIDTH, MAX_W_X);
      height <= bfd_pkg::clamp_size(bfd_pkg::RESET_HEIGHT, MAX_H_X);
      col    <= '0;
      row    <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          bfd_pkg::REG_FRAME_WIDTH:  width  <= bfd_pkg::clamp_size(cfg.data, MAX_W_X);
          bfd_pkg::REG_FRAME_HEIGHT: height <= bfd_pkg::clamp_size(cfg.data, MAX_H_X);
        endcase
      end
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_block && !col_odd) begin
      first <= pix;
    end
  end

  a_no_rw_overlap : assert property (@(posedge clk) disable iff (rst)
    !(wr.en && rd.en))
    else $error("line store read and write in the same cycle");

  a_read_not_after_write : assert property (@(posedge clk) disable iff (rst)
    wr.en |=> !rd.en)
    else $error("line store read directly after a write");

  a_col_wrap : assert property (@(posedge clk) disable iff (rst)
    (accept && (col_x >= w_last)) |=> (col == '0))
    else $error("column counter failed to wrap");

endmodule

`default_nettype wire

// ----- rtl/core/bfd_avg.sv -----
// ----------------------------------------------------------------------------
// bfd_avg: block completion and output register
// Adds the fetched pair sums to the current pair and rounds to a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_avg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bfd_pkg::issue_t issue,
  input  wire bfd_pkg::sum_t   above,
  output      logic            ready,
  bfd_out_if.source            pix_out
);

  logic              s1_valid;
  logic              s1_last;
  bfd_pkg::sum_t     s1_pair;
  logic              out_valid;
  logic              out_free;
  logic              s1_move;
  bfd_pkg::pix_t     out_pix;
  logic              out_last;

  assign out_free = !out_valid || pix_out.ready;
  assign s1_move  = s1_valid && out_free;
  assign ready    = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready) begin
        s1_valid <= issue.valid;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && issue.valid) begin
      s1_last <= issue.last;
      s1_pair <= issue.pair;
    end
    if (s1_move) begin
      out_pix.red   <= bfd_pkg::avg_channel(above.red,   s1_pair.red);
      out_pix.green <= bfd_pkg::avg_channel(above.green, s1_pair.green);
      out_pix.blue  <= bfd_pkg::avg_channel(above.blue,  s1_pair.blue);
      out_last      <= s1_last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.red_out    = out_pix.red;
  assign pix_out.green_out  = out_pix.green;
  assign pix_out.blue_out   = out_pix.blue;
  assign pix_out.frame_last = out_last;

  a_issue_when_ready : assert property (@(posedge clk) disable iff (rst)
    issue.valid |-> ready)
    else $error("block issued while the stage is full");

  a_issue_lands : assert property (@(posedge clk) disable iff (rst)
    issue.valid |=> s1_valid)
    else $error("issued block lost");

  a_stage_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_pair)))
    else $error("stalled block changed");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for box_filter_downscale_by_two_unit
// Streams RGB frames of many sizes through the downscaler and checks every
// averaged pixel and end-of-frame flag against a cycle-free model of the
// raster counters, the pair sums and the line store. The two sides of the
// stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD     = 8;
  localparam int HALF_PERIOD    = CLK_PERIOD / 2;
  localparam int RESET_CYCLES   = 2;
  localparam int SETTLE_CYCLES  = 6;        // well past the block's latency
  localparam int TIMEOUT_CYCLES = 500_000;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int REPORT_LIMIT   = 10;
  localparam int MIN_DIM        = 2;
  localparam int ROUND_UP       = 2;

  // One averaged pixel as it should leave the block.
  typedef struct packed {
    logic [bfd_pkg::CH_W-1:0] red;
    logic [bfd_pkg::CH_W-1:0] green;
    logic [bfd_pkg::CH_W-1:0] blue;
    logic                     last;
  } out_pixel_t;

  logic clk;
  logic rst;

  bfd_cfg_if cfg_ch ();
  bfd_in_if  pix_in_ch ();
  bfd_out_if pix_out_ch ();

  box_filter_downscale_by_two_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pix_in  (pix_in_ch),
    .pix_out (pix_out_ch)
  );

  // Pixels waiting to be offered, and averaged pixels still owed by the block.
  bfd_pkg::pix_t pending_pixels [$];
  out_pixel_t    expected_pixels [$];

  // Shadow of the block: configured sizes, raster position, the first pixel
  // of the current horizontal pair and the line store of pair sums.
  logic [bfd_pkg::SIZE_W-1:0] width_reg;
  logic [bfd_pkg::SIZE_W-1:0] height_reg;
  logic [bfd_pkg::SIZE_W-1:0] col_pos;
  logic [bfd_pkg::SIZE_W-1:0] row_pos;
  bfd_pkg::sum_t              held_sum;
  bfd_pkg::sum_t              line_sums [bfd_pkg::LINE_DEPTH];

  int src_idle_pct;
  int snk_stall_pct;
  int mismatches;

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  function automatic int unsigned clip_dim(input logic [bfd_pkg::SIZE_W-1:0] v,
                                           input int unsigned top);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // Mean of four channel values given as two pair sums, rounding half up.
  function automatic logic [bfd_pkg::CH_W-1:0] block_mean(
      input logic [bfd_pkg::SUM_W-1:0] upper,
      input logic [bfd_pkg::SUM_W-1:0] lower);
    return bfd_pkg::CH_W'((int'(upper) + int'(lower) + ROUND_UP) / 4);
  endfunction

  function automatic logic [bfd_pkg::CH_W-1:0] random_channel();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return bfd_pkg::CH_W'($urandom);
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic reset_shadow();
    width_reg  = bfd_pkg::RESET_WIDTH;
    height_reg = bfd_pkg::RESET_HEIGHT;
    col_pos    = '0;
    row_pos    = '0;
    held_sum   = '0;
  endtask

  // Advances the shadow by one accepted pixel and records the averaged pixel
  // that it completes, if any.
  task automatic downscale_pixel(input bfd_pkg::pix_t p);
    int unsigned   w, h, ow, oh, ocol, orow, slot;
    bfd_pkg::sum_t here, pair, above;
    out_pixel_t    res;
    w    = clip_dim(width_reg, bfd_pkg::MAX_WIDTH);
    h    = clip_dim(height_reg, bfd_pkg::MAX_HEIGHT);
    ow   = w / 2;
    oh   = h / 2;
    ocol = col_pos >> 1;
    orow = row_pos >> 1;
    here = '{blue: bfd_pkg::SUM_W'(p.blue), green: bfd_pkg::SUM_W'(p.green),
             red: bfd_pkg::SUM_W'(p.red)};
    // Pixels of a trailing odd column or odd last row fall outside every block.
    if (ocol < ow && orow < oh) begin
      if (!col_pos[0]) begin
        held_sum = here;
      end else begin
        pair.red   = held_sum.red + here.red;
        pair.green = held_sum.green + here.green;
        pair.blue  = held_sum.blue + here.blue;
        slot = ocol % bfd_pkg::LINE_DEPTH;
        if (!row_pos[0]) begin
          line_sums[slot] = pair;
        end else begin
          above     = line_sums[slot];
          res.red   = block_mean(above.red, pair.red);
          res.green = block_mean(above.green, pair.green);
          res.blue  = block_mean(above.blue, pair.blue);
          res.last  = (ocol == ow - 1) && (orow == oh - 1);
          expected_pixels = {expected_pixels, res};
        end
      end
    end
    // A position at or past the last column or row, possibly after a size
    // change, wraps to the start of the line or of the frame.
    if (col_pos >= w - 1) begin
      col_pos = '0;
      if (row_pos >= h - 1) row_pos = '0;
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
      if (row_pos > h - 1) row_pos = '0;
    end
  endtask

  // Pixel source: offers the next queued pixel unless it chooses to idle, and
  // feeds the shadow with each pixel at the edge of its transfer.
  always @(posedge clk) begin : pixel_driver
    bfd_pkg::pix_t next_pix;
    if (rst) begin
      pix_in_ch.valid <= 1'b0;
      reset_shadow();
    end else begin
      if (pix_in_ch.valid && pix_in_ch.ready) begin
        downscale_pixel('{blue: pix_in_ch.blue_in, green: pix_in_ch.green_in,
                          red: pix_in_ch.red_in});
      end
      if (!pix_in_ch.valid || pix_in_ch.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_pix = pending_pixels.pop_front();
          pix_in_ch.red_in   <= next_pix.red;
          pix_in_ch.green_in <= next_pix.green;
          pix_in_ch.blue_in  <= next_pix.blue;
          pix_in_ch.valid    <= 1'b1;
        end else begin
          pix_in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: stalls at random and compares every transfer with the
  // oldest averaged pixel still owed.
  always @(posedge clk) begin : result_monitor
    out_pixel_t want;
    if (rst) begin
      pix_out_ch.ready <= 1'b0;
    end else begin
      if (pix_out_ch.valid && pix_out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0b",
                               pix_out_ch.red_out, pix_out_ch.green_out,
                               pix_out_ch.blue_out, pix_out_ch.frame_last));
        end else begin
          want = expected_pixels.pop_front();
          if (pix_out_ch.red_out !== want.red)
            flag_error($sformatf("red expected %0d, got %0d", want.red, pix_out_ch.red_out));
          if (pix_out_ch.green_out !== want.green)
            flag_error($sformatf("green expected %0d, got %0d", want.green,
                                 pix_out_ch.green_out));
          if (pix_out_ch.blue_out !== want.blue)
            flag_error($sformatf("blue expected %0d, got %0d", want.blue,
                                 pix_out_ch.blue_out));
          if (pix_out_ch.frame_last !== want.last)
            flag_error($sformatf("frame_last expected %0b, got %0b", want.last,
                                 pix_out_ch.frame_last));
        end
      end
      pix_out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // One register write; the shadow takes the new value at the edge of the
  // transfer, which only ever happens while the block is idle.
  task automatic write_reg(input bfd_pkg::cfg_index_t idx,
                           input logic [bfd_pkg::SIZE_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == bfd_pkg::REG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [bfd_pkg::SIZE_W-1:0] w,
                           input logic [bfd_pkg::SIZE_W-1:0] h);
    write_reg(bfd_pkg::REG_FRAME_WIDTH, w);
    write_reg(bfd_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic push_pixel(input logic [bfd_pkg::CH_W-1:0] r,
                            input logic [bfd_pkg::CH_W-1:0] g,
                            input logic [bfd_pkg::CH_W-1:0] b);
    bfd_pkg::pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    pending_pixels = {pending_pixels, p};
  endtask

  task automatic push_random_pixels(input int count);
    for (int i = 0; i < count; i++) push_pixel(random_channel(), random_channel(), random_channel());
  endtask

  // Waits until every queued pixel has been taken and every owed pixel has
  // arrived, then lets the pipeline run dry, since the last pixels of a frame
  // may leave no result behind them. The check is made between edges, once
  // the driver and the monitor have settled.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || pix_in_ch.valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int batch;
    int random_pixels;
    int frames;
    int unsigned w, h;

    // Every input of the block is known from the very start.
    rst                = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = bfd_pkg::REG_FRAME_WIDTH;
    cfg_ch.data        = '0;
    pix_in_ch.valid    = 1'b0;
    pix_in_ch.red_in   = '0;
    pix_in_ch.green_in = '0;
    pix_in_ch.blue_in  = '0;
    pix_out_ch.ready   = 1'b0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    mismatches         = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame: a single block of full-scale pixels, which is also the
    // last pixel of its frame.
    set_frame(13'd2, 13'd2);
    repeat (4) push_pixel('1, '1, '1);
    wait_idle();

    // Odd width and height: the third column and third row produce nothing.
    // The one block holds a sum just below a half, a sum of exactly one half,
    // which must round up, and a near-maximum sum.
    set_frame(13'd3, 13'd3);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_random_pixels(1);
    push_pixel(8'd0, 8'd1, 8'd255);
    push_pixel(8'd1, 8'd1, 8'd254);
    push_random_pixels(4);
    wait_idle();

    // Width narrowed in mid-frame: the column position is already past the
    // new last column, so it wraps at the end of the next pixel and the frame
    // goes on with the new width.
    set_frame(13'd4, 13'd4);
    push_random_pixels(6);
    wait_idle();
    write_reg(bfd_pkg::REG_FRAME_WIDTH, 13'd2);
    push_random_pixels(5);
    wait_idle();

    // Height lowered in mid-frame while inside a line: the row position lies
    // beyond the new last row and drops to the first row before the line
    // ends. The odd row that follows reads pair sums left by earlier rows.
    set_frame(13'd3, 13'd6);
    push_random_pixels(13);
    wait_idle();
    write_reg(bfd_pkg::REG_FRAME_HEIGHT, 13'd2);
    push_random_pixels(5);
    wait_idle();

    // Sizes out of range are clipped: a width of one and a zero height give
    // the smallest frame, all-ones sizes the largest one. The large frame is
    // left after part of its first line, and a small frame takes over.
    src_idle_pct  = 24;
    snk_stall_pct = 24;
    set_frame(13'd1, 13'd0);
    push_random_pixels(4);
    wait_idle();
    set_frame('1, '1);
    push_random_pixels(16);
    wait_idle();
    set_frame(13'd2, 13'd2);
    push_random_pixels(7);
    wait_idle();

    // Random part: batches of back-to-back frames of one random size, mostly
    // small, the idling pattern changing from batch to batch.
    batch         = 0;
    random_pixels = 0;
    while (random_pixels < RANDOM_ITEMS) begin
      case (batch % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 24; snk_stall_pct = 24; end
      endcase
      if ($urandom_range(99) < 85) begin
        w = $urandom_range(MIN_DIM, 12);
        h = $urandom_range(MIN_DIM, 12);
      end else begin
        w = $urandom_range(MIN_DIM, 64);
        h = $urandom_range(MIN_DIM, 16);
      end
      set_frame(bfd_pkg::SIZE_W'(w), bfd_pkg::SIZE_W'(h));
      frames = $urandom_range(1, 3);
      push_random_pixels(int'(frames * w * h));
      random_pixels += int'(frames * w * h);
      wait_idle();
      batch++;
    end

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("status: fail");
    $finish;
  end

endmodule
